### hdl/source_text_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Uses the clock and reset names of the module that includes it.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// condition holds whenever the antecedent holds, same cycle
`define STT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// condition holds in the cycle after the antecedent
`define STT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

### hdl/stt_pkg.sv
// Types, codes and character classes for the source text tokenizer.
// No dependencies.
`default_nettype none

package stt_pkg;

   localparam int TokenLimitDefault = 1024;
   localparam int NameMaxDefault    = 31;
   localparam int NAME_BYTES        = 31;

   // token kinds
   localparam logic [3:0] KIND_EOF    = 4'd0;
   localparam logic [3:0] KIND_IDENT  = 4'd1;
   localparam logic [3:0] KIND_NUMBER = 4'd2;
   localparam logic [3:0] KIND_INT    = 4'd3;
   localparam logic [3:0] KIND_PRINT  = 4'd4;
   localparam logic [3:0] KIND_IF     = 4'd5;
   localparam logic [3:0] KIND_ELSE   = 4'd6;
   localparam logic [3:0] KIND_WHILE  = 4'd7;
   localparam logic [3:0] KIND_SYMBOL = 4'd8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DIG0  = 8'h30;
   localparam logic [7:0] CH_DIG9  = 8'h39;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;

   // keyword text, first character in the most significant byte
   localparam logic [23:0] KW_INT   = "int";
   localparam logic [39:0] KW_PRINT = "print";
   localparam logic [15:0] KW_IF    = "if";
   localparam logic [31:0] KW_ELSE  = "else";
   localparam logic [39:0] KW_WHILE = "while";

   typedef struct packed {
      logic [7:0] source_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]         token_kind;
      logic signed [31:0] number_value;
      logic [7:0]         symbol_first;
      logic [7:0]         symbol_second;
      logic [4:0]         name_length;
      logic [63:0]        name_chars_a;
      logic [63:0]        name_chars_b;
      logic [63:0]        name_chars_c;
      logic [55:0]        name_chars_d;
      logic               run_end;
   } rsp_type;

   function automatic logic is_word_start(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= CH_DIG0 && c <= CH_DIG9;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic pairs_with_eq(input logic [7:0] c);
      return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT;
   endfunction

endpackage

`default_nettype wire

### hdl/source_text_tokenizer.sv
// Source text tokenizer: byte-stream lexer for a small C-like language.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
//
// One source byte is taken per cycle and lexed in a single registered pass;
// its tokens (up to three: a pending token, the byte's own token and EOF)
// are written at once into a four-entry result queue that drains one token
// per cycle while rsp_ready is high. A new byte is accepted whenever the
// queue holds at most one token, so a stream whose bytes yield at most one
// token each runs at one byte per cycle; a byte that yields k tokens sends
// them out one at a time. Identifiers longer than NAME_MAX characters are
// split, numbers wrap modulo 2^32, and once TOKEN_LIMIT-1 tokens are out EOF
// is sent and the rest of the source is dropped up to its zero byte or final
// byte.
`default_nettype none

`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int TOKEN_LIMIT = TokenLimitDefault,
   parameter int NAME_MAX    = NameMaxDefault
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data
);

   localparam int TALLY_W = $clog2(TOKEN_LIMIT);
   localparam logic [TALLY_W:0] TALLY_LAST = (TALLY_W + 1)'(TOKEN_LIMIT - 1);
   localparam logic [4:0] NAME_LAST = 5'(NAME_MAX);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_NAME    = 3'd2;
   localparam logic [2:0] MODE_NUMBER  = 3'd3;
   localparam logic [2:0] MODE_HELD    = 3'd4;
   localparam logic [2:0] MODE_DONE    = 3'd5;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] s0;
      logic [7:0] s1;
   } tok_type;

   // lexer state
   logic [2:0]         mode_ff, mode_in;
   logic [7:0]         held_ff, held_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        acc_ff, acc_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [7:0]         name_ff [NAME_BYTES];

   // result queue
   rsp_type    fifo_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] fifo_count_ff, fifo_count_in;

   logic       accept, pop, ends, stop0, stop1;
   logic [7:0] c;
   logic [2:0] lex_mode;
   logic [7:0] lex_held;
   logic [4:0] lex_cnt;
   logic [31:0] lex_acc;
   logic       name_we;
   logic [4:0] name_wa;
   logic [7:0] name_wd;
   tok_type    tok [2];
   logic [1:0] nk;
   logic [1:0] nres;
   logic [TALLY_W:0] sum1, sum2;
   logic [3:0] name_kind;
   logic [8*NAME_BYTES-1:0] name_flat;
   tok_type    res_tok [3];
   rsp_type    res [4];

   assign c      = req_data.source_byte;
   assign ends   = (c == CH_NUL) || req_data.final_byte;
   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   assign req_ready = fifo_count_ff <= 3'd1;
   assign rsp_valid = fifo_count_ff != 3'd0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // one byte through the lexer; tokens collect in tok[] in emit order
   always_comb begin
      logic fresh;
      fresh    = 1'b0;
      lex_mode = mode_ff;
      lex_held = held_ff;
      lex_cnt  = cnt_ff;
      lex_acc  = acc_ff;
      name_we  = 1'b0;
      name_wa  = 5'd0;
      name_wd  = 8'h00;
      tok[0]   = '0;
      tok[1]   = '0;
      nk       = 2'd0;

      if (mode_ff != MODE_DONE && c != CH_NUL) begin
         fresh = 1'b1;
         if (mode_ff == MODE_COMMENT) begin
            fresh = 1'b0;
            if (c == CH_LF) lex_mode = MODE_IDLE;
         end else if (mode_ff == MODE_HELD) begin
            lex_mode = MODE_IDLE;
            lex_held = 8'h00;
            if (held_ff == CH_SLASH && c == CH_SLASH) begin
               lex_mode = MODE_COMMENT;
               fresh    = 1'b0;
            end else if (pairs_with_eq(held_ff) && c == CH_EQ) begin
               tok[nk[0]] = '{kind: KIND_SYMBOL, s0: held_ff, s1: CH_EQ};
               nk         = nk + 2'd1;
               fresh      = 1'b0;
            end else begin
               tok[nk[0]] = '{kind: KIND_SYMBOL, s0: held_ff, s1: 8'h00};
               nk         = nk + 2'd1;
            end
         end else if (mode_ff == MODE_NAME) begin
            if (is_word_start(c) || is_decimal(c)) begin
               fresh   = 1'b0;
               name_we = 1'b1;
               name_wa = cnt_ff;
               name_wd = c;
               lex_cnt = cnt_ff + 5'd1;
               if (lex_cnt >= NAME_LAST) begin
                  tok[nk[0]] = '{kind: KIND_IDENT, s0: 8'h00, s1: 8'h00};
                  nk         = nk + 2'd1;
                  lex_mode   = MODE_IDLE;
               end
            end else begin
               tok[nk[0]] = '{kind: KIND_IDENT, s0: 8'h00, s1: 8'h00};
               nk         = nk + 2'd1;
               lex_mode   = MODE_IDLE;
            end
         end else if (mode_ff == MODE_NUMBER) begin
            if (is_decimal(c)) begin
               fresh   = 1'b0;
               lex_acc = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + 32'(c[3:0]);
            end else begin
               tok[nk[0]] = '{kind: KIND_NUMBER, s0: 8'h00, s1: 8'h00};
               nk         = nk + 2'd1;
               lex_mode   = MODE_IDLE;
            end
         end

         if (fresh && !is_space(c)) begin
            if (c == CH_SLASH || pairs_with_eq(c)) begin
               lex_held = c;
               lex_mode = MODE_HELD;
            end else if (is_word_start(c)) begin
               name_we  = 1'b1;
               name_wa  = 5'd0;
               name_wd  = c;
               lex_cnt  = 5'd1;
               lex_mode = MODE_NAME;
               if (lex_cnt >= NAME_LAST) begin
                  tok[nk[0]] = '{kind: KIND_IDENT, s0: 8'h00, s1: 8'h00};
                  nk         = nk + 2'd1;
                  lex_mode   = MODE_IDLE;
               end
            end else if (is_decimal(c)) begin
               lex_acc  = 32'(c[3:0]);
               lex_mode = MODE_NUMBER;
            end else begin
               tok[nk[0]] = '{kind: KIND_SYMBOL, s0: c, s1: 8'h00};
               nk         = nk + 2'd1;
            end
         end
      end

      // end of source flushes whatever is still pending
      if (mode_ff != MODE_DONE && ends) begin
         if (lex_mode == MODE_HELD) begin
            tok[nk[0]] = '{kind: KIND_SYMBOL, s0: lex_held, s1: 8'h00};
            nk         = nk + 2'd1;
         end else if (lex_mode == MODE_NAME) begin
            tok[nk[0]] = '{kind: KIND_IDENT, s0: 8'h00, s1: 8'h00};
            nk         = nk + 2'd1;
         end else if (lex_mode == MODE_NUMBER) begin
            tok[nk[0]] = '{kind: KIND_NUMBER, s0: 8'h00, s1: 8'h00};
            nk         = nk + 2'd1;
         end
      end
   end

   // name text after this byte's append, zero past the length
   always_comb begin
      logic [7:0] view;
      for (int i = 0; i < NAME_BYTES; i++) begin
         view = (name_we && name_wa == 5'(i)) ? name_wd : name_ff[i];
         name_flat[8*i +: 8] = (5'(i) < lex_cnt) ? view : 8'h00;
      end
   end

   always_comb begin
      name_kind = KIND_IDENT;
      if (lex_cnt == 5'd3 && {name_flat[7:0], name_flat[15:8], name_flat[23:16]} == KW_INT)
         name_kind = KIND_INT;
      else if (lex_cnt == 5'd5 && {name_flat[7:0], name_flat[15:8], name_flat[23:16],
                                   name_flat[31:24], name_flat[39:32]} == KW_PRINT)
         name_kind = KIND_PRINT;
      else if (lex_cnt == 5'd2 && {name_flat[7:0], name_flat[15:8]} == KW_IF)
         name_kind = KIND_IF;
      else if (lex_cnt == 5'd4 && {name_flat[7:0], name_flat[15:8], name_flat[23:16],
                                   name_flat[31:24]} == KW_ELSE)
         name_kind = KIND_ELSE;
      else if (lex_cnt == 5'd5 && {name_flat[7:0], name_flat[15:8], name_flat[23:16],
                                   name_flat[31:24], name_flat[39:32]} == KW_WHILE)
         name_kind = KIND_WHILE;
   end

   // token limit cut; an all-zero descriptor is EOF
   always_comb begin
      sum1  = {1'b0, tally_ff} + (TALLY_W + 1)'(1);
      sum2  = {1'b0, tally_ff} + (TALLY_W + 1)'(2);
      stop0 = (nk != 2'd0) && (sum1 >= TALLY_LAST);
      stop1 = (nk == 2'd2) && !stop0 && (sum2 >= TALLY_LAST);
      res_tok[0] = tok[0];
      res_tok[1] = stop0 ? tok_type'('0) : tok[1];
      res_tok[2] = '0;
      if (mode_ff == MODE_DONE)
         nres = 2'd0;
      else if (stop0)
         nres = 2'd2;
      else if (stop1)
         nres = 2'd3;
      else
         nres = nk + {1'b0, ends};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res[i]               = '0;
         res[i].token_kind    = res_tok[i].kind;
         res[i].symbol_first  = res_tok[i].s0;
         res[i].symbol_second = res_tok[i].s1;
         if (res_tok[i].kind == KIND_NUMBER)
            res[i].number_value = lex_acc;
         if (res_tok[i].kind == KIND_IDENT) begin
            res[i].token_kind   = name_kind;
            res[i].name_length  = lex_cnt;
            res[i].name_chars_a = name_flat[63:0];
            res[i].name_chars_b = name_flat[127:64];
            res[i].name_chars_c = name_flat[191:128];
            res[i].name_chars_d = name_flat[247:192];
         end
         res[i].run_end = (2'(i) + 2'd1) == nres;
      end
      res[3] = '0;
   end

   // next lexer state
   always_comb begin
      mode_in  = mode_ff;
      held_in  = held_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      tally_in = tally_ff;
      if (accept) begin
         if (ends) begin
            mode_in  = MODE_IDLE;
            held_in  = 8'h00;
            cnt_in   = 5'd0;
            acc_in   = 32'd0;
            tally_in = '0;
         end else if (mode_ff == MODE_DONE) begin
            mode_in = MODE_DONE;
         end else if (stop0 || stop1) begin
            mode_in = MODE_DONE;
         end else begin
            mode_in  = lex_mode;
            held_in  = lex_held;
            cnt_in   = lex_cnt;
            acc_in   = lex_acc;
            tally_in = tally_ff + TALLY_W'(nk);
         end
      end
   end

   always_comb begin
      rd_ptr_in     = rd_ptr_ff + {1'b0, pop};
      wr_ptr_in     = accept ? wr_ptr_ff + nres : wr_ptr_ff;
      fifo_count_in = fifo_count_ff + (accept ? {1'b0, nres} : 3'd0) - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_ff       <= 8'h00;
         cnt_ff        <= 5'd0;
         acc_ff        <= 32'd0;
         tally_ff      <= '0;
         rd_ptr_ff     <= 2'd0;
         wr_ptr_ff     <= 2'd0;
         fifo_count_ff <= 3'd0;
      end else begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         cnt_ff        <= cnt_in;
         acc_ff        <= acc_in;
         tally_ff      <= tally_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && name_we) name_ff[name_wa] <= name_wd;
   end

   // a transaction's results land at consecutive slots from the write pointer
   always_ff @(posedge clock) begin
      logic [1:0] offset;
      for (int i = 0; i < 4; i++) begin
         offset = 2'(i) - wr_ptr_ff;
         if (accept && {1'b0, offset} < {1'b0, nres}) fifo_ff[i] <= res[offset];
      end
   end

   `STT_ASSERT_IMP(a_held_nonzero, mode_ff == MODE_HELD, held_ff != 8'h00)
   `STT_ASSERT_IMP(a_name_count_range, mode_ff == MODE_NAME,
                   cnt_ff != 5'd0 && cnt_ff < NAME_LAST)
   `STT_ASSERT_IMP(a_tally_below_limit, mode_ff != MODE_DONE,
                   {1'b0, tally_ff} < TALLY_LAST)
   `STT_ASSERT_NXT(a_end_resets, accept && ends,
                   mode_ff == MODE_IDLE && tally_ff == '0)
   `STT_ASSERT_NXT(a_done_silent, accept && mode_ff == MODE_DONE,
                   fifo_count_ff <= $past(fifo_count_ff))

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for source_text_tokenizer: streams source bytes in,
// predicts the token stream with its own lexer model and checks every token.
// Depends on stt_pkg and the source_text_tokenizer RTL.

module tb;
   import stt_pkg::*;

   localparam int TOKEN_CAP   = TokenLimitDefault;
   localparam int NAME_CAP    = NameMaxDefault;
   localparam int RANDOM_BYTES = 420;
   localparam longint unsigned CYCLE_LIMIT = 200000;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_COMMENT, SCAN_NAME, SCAN_NUMBER, SCAN_HELD, SCAN_DONE
   } scan_state_type;

   typedef enum logic [2:0] {
      CC_BLANK, CC_LETTER, CC_DIGIT, CC_SLASH, CC_PAIRABLE, CC_OTHER
   } char_class_type;

   typedef struct {
      rsp_type         token;
      longint unsigned cycle;
   } pending_token_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // lexer model state
   scan_state_type scan_state;
   logic [7:0]   held_char;
   logic [255:0] name_bits;
   int unsigned  name_len;
   logic [31:0]  number_acc;
   int unsigned  tokens_in_source;
   rsp_type      step_tokens[$];

   req_type           pending_bytes[$];
   pending_token_type expected_tokens[$];

   longint unsigned cycle_count    = 0;
   int unsigned     bytes_queued   = 0;
   int unsigned     bytes_accepted = 0;
   int unsigned     sources_done   = 0;
   int unsigned     limit_hits     = 0;
   int unsigned     tokens_checked = 0;
   int unsigned     error_count    = 0;
   int unsigned     hold_left      = 0;
   bit              hold_done      = 1'b0;

   string keywords[5] = '{"int", "print", "if", "else", "while"};
   string name_head   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string name_tail   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string punct       = ";(){}+-*,=!<>/%&|";
   string blanks      = " \t\r\n";
   string tail_chars  = "a9=/;< \n";

   // no random idling on either side inside this window
   wire quiet = cycle_count >= 300 && cycle_count < 500;

   source_text_tokenizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- lexer model

   function automatic char_class_type classify_char(input logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return CC_BLANK;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CC_LETTER;
      if (c >= "0" && c <= "9") return CC_DIGIT;
      if (c == "/") return CC_SLASH;
      if (c == "=" || c == "!" || c == "<" || c == ">") return CC_PAIRABLE;
      return CC_OTHER;
   endfunction

   function automatic void clear_lexer();
      scan_state       = SCAN_IDLE;
      held_char        = '0;
      name_bits        = '0;
      name_len         = 0;
      number_acc       = '0;
      tokens_in_source = 0;
   endfunction

   function automatic void queue_token(input logic [3:0] kind, input logic [31:0] value,
                                       input logic [7:0] first, input logic [7:0] second,
                                       input bit named);
      rsp_type t;
      t = '0;
      t.token_kind    = kind;
      t.number_value  = value;
      t.symbol_first  = first;
      t.symbol_second = second;
      if (named) begin
         t.name_length  = name_len[4:0];
         t.name_chars_a = name_bits[63:0];
         t.name_chars_b = name_bits[127:64];
         t.name_chars_c = name_bits[191:128];
         t.name_chars_d = name_bits[247:192];
      end
      step_tokens.push_back(t);
   endfunction

   // returns 1 when this token used up the source's token budget
   function automatic bit send_token(input logic [3:0] kind, input logic [31:0] value,
                                     input logic [7:0] first, input logic [7:0] second,
                                     input bit named);
      queue_token(kind, value, first, second, named);
      tokens_in_source++;
      if (tokens_in_source >= TOKEN_CAP - 1) begin
         queue_token(KIND_EOF, '0, '0, '0, 1'b0);
         scan_state = SCAN_DONE;
         limit_hits++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // name bytes are little endian, so keyword literals are written reversed
   function automatic logic [3:0] name_kind();
      case (name_len)
         2: if (name_bits[15:0] == {"f", "i"}) return KIND_IF;
         3: if (name_bits[23:0] == {"t", "n", "i"}) return KIND_INT;
         4: if (name_bits[31:0] == {"e", "s", "l", "e"}) return KIND_ELSE;
         5: begin
            if (name_bits[39:0] == {"t", "n", "i", "r", "p"}) return KIND_PRINT;
            if (name_bits[39:0] == {"e", "l", "i", "h", "w"}) return KIND_WHILE;
         end
         default: ;
      endcase
      return KIND_IDENT;
   endfunction

   function automatic bit emit_name();
      logic [3:0] kind;
      kind = name_kind();
      scan_state = SCAN_IDLE;
      return send_token(kind, '0, '0, '0, 1'b1);
   endfunction

   function automatic bit append_char(input logic [7:0] c);
      if (name_len < 31) begin
         name_bits[name_len*8 +: 8] = c;
         name_len++;
      end
      if (name_len >= NAME_CAP) return emit_name();
      return 1'b0;
   endfunction

   function automatic bit lex_char(input logic [7:0] c);
      char_class_type cls;
      logic [7:0]     h;
      cls = classify_char(c);
      case (scan_state)
         SCAN_COMMENT: begin
            if (c == CH_LF) scan_state = SCAN_IDLE;
            return 1'b0;
         end
         SCAN_HELD: begin
            h = held_char;
            held_char = '0;
            scan_state = SCAN_IDLE;
            if (h == CH_SLASH && c == CH_SLASH) begin
               scan_state = SCAN_COMMENT;
               return 1'b0;
            end
            if (h != CH_SLASH && c == CH_EQ) return send_token(KIND_SYMBOL, '0, h, CH_EQ, 1'b0);
            // lookahead miss: held symbol goes out alone, byte is lexed afresh
            if (send_token(KIND_SYMBOL, '0, h, '0, 1'b0)) return 1'b1;
         end
         SCAN_NAME: begin
            if (cls == CC_LETTER || cls == CC_DIGIT) return append_char(c);
            if (emit_name()) return 1'b1;
         end
         SCAN_NUMBER: begin
            if (cls == CC_DIGIT) begin
               number_acc = number_acc * 32'd10 + 32'(c - CH_DIG0);
               return 1'b0;
            end
            scan_state = SCAN_IDLE;
            if (send_token(KIND_NUMBER, number_acc, '0, '0, 1'b0)) return 1'b1;
         end
         default: ;
      endcase
      case (cls)
         CC_BLANK: return 1'b0;
         CC_SLASH, CC_PAIRABLE: begin
            held_char = c;
            scan_state = SCAN_HELD;
            return 1'b0;
         end
         CC_LETTER: begin
            name_bits = '0;
            name_len = 0;
            scan_state = SCAN_NAME;
            return append_char(c);
         end
         CC_DIGIT: begin
            number_acc = 32'(c - CH_DIG0);
            scan_state = SCAN_NUMBER;
            return 1'b0;
         end
         default: ;
      endcase
      return send_token(KIND_SYMBOL, '0, c, '0, 1'b0);
   endfunction

   // work out the tokens of one accepted byte and queue them as expectations
   function automatic void predict_tokens(input req_type item);
      bit                ends;
      bit                stopped;
      pending_token_type entry;
      step_tokens.delete();
      bytes_accepted++;
      ends = item.source_byte == CH_NUL || item.final_byte;
      stopped = 1'b0;
      if (scan_state == SCAN_DONE) begin
         // past the token limit: drop bytes until the source ends
         if (ends) begin
            clear_lexer();
            sources_done++;
         end
         return;
      end
      if (item.source_byte != CH_NUL) stopped = lex_char(item.source_byte);
      if (ends) begin
         if (!stopped) begin
            case (scan_state)
               SCAN_HELD:   stopped = send_token(KIND_SYMBOL, '0, held_char, '0, 1'b0);
               SCAN_NAME:   stopped = emit_name();
               SCAN_NUMBER: stopped = send_token(KIND_NUMBER, number_acc, '0, '0, 1'b0);
               default: ;
            endcase
            if (!stopped) queue_token(KIND_EOF, '0, '0, '0, 1'b0);
         end
         clear_lexer();
         sources_done++;
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         entry.token = step_tokens[i];
         entry.token.run_end = (i == step_tokens.size() - 1);
         entry.cycle = cycle_count;
         expected_tokens.push_back(entry);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_tokens(req_data);
         if (req_valid && !req_ready) begin
            // hold the offered byte until it is taken
         end else if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
            req_valid <= 1'b1;
            req_data  <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      bit holding;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         holding = hold_left != 0 || (!hold_done && tokens_checked >= 80);
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && tokens_checked >= 80) begin
            // long back-pressure stretch so the output queue fills up
            hold_left <= 80;
            hold_done <= 1'b1;
         end
         rsp_ready <= !holding && (quiet || $urandom_range(99) >= 25);
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_checked <= tokens_checked + 1;
         // expectations from a byte taken at this same edge are not yet due
         if (expected_tokens.size() == 0 || expected_tokens[0].cycle >= cycle_count) begin
            $error("unexpected token transaction, kind %0d", rsp_data.token_kind);
            error_count++;
         end else begin
            want = expected_tokens.pop_front().token;
            check_field("token_kind", 64'(want.token_kind), 64'(rsp_data.token_kind));
            check_field("number_value", 64'(want.number_value), 64'(rsp_data.number_value));
            check_field("symbol_first", 64'(want.symbol_first), 64'(rsp_data.symbol_first));
            check_field("symbol_second", 64'(want.symbol_second),
                        64'(rsp_data.symbol_second));
            check_field("name_length", 64'(want.name_length), 64'(rsp_data.name_length));
            check_field("name_chars_a", want.name_chars_a, rsp_data.name_chars_a);
            check_field("name_chars_b", want.name_chars_b, rsp_data.name_chars_b);
            check_field("name_chars_c", want.name_chars_c, rsp_data.name_chars_c);
            check_field("name_chars_d", 64'(want.name_chars_d), 64'(rsp_data.name_chars_d));
            check_field("run_end", 64'(want.run_end), 64'(rsp_data.run_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens still expected",
                  cycle_count, expected_tokens.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(input logic [7:0] c, input bit fin);
      req_type item;
      item.source_byte = c;
      item.final_byte  = fin;
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   task automatic add_text(input string s, input bit fin_on_last);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], fin_on_last && i == s.len() - 1);
   endtask

   task automatic add_random_token();
      int          len;
      string       s;
      case ($urandom_range(9))
         0: add_text(keywords[$urandom_range(4)], 1'b0);
         1, 2: begin
            // mostly short names, some long enough to be split
            len = ($urandom_range(4) == 0) ? $urandom_range(28, 45) : $urandom_range(1, 8);
            add_byte(name_head[$urandom_range(name_head.len() - 1)], 1'b0);
            for (int i = 1; i < len; i++)
               add_byte(name_tail[$urandom_range(name_tail.len() - 1)], 1'b0);
         end
         3: begin
            len = ($urandom_range(3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) add_byte(8'(CH_DIG0 + $urandom_range(9)), 1'b0);
         end
         4: begin
            s = "=!<>";
            add_byte(s[$urandom_range(3)], 1'b0);
            add_byte(CH_EQ, 1'b0);
         end
         5: begin
            add_text("//", 1'b0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) add_byte(8'($urandom_range(1, 255)), 1'b0);
            add_byte(CH_LF, 1'b0);
         end
         6: add_byte(8'($urandom_range(1, 255)), 1'b0);
         default: add_byte(punct[$urandom_range(punct.len() - 1)], 1'b0);
      endcase
      if ($urandom_range(1) == 0) begin
         len = $urandom_range(1, 2);
         for (int i = 0; i < len; i++) add_byte(blanks[$urandom_range(3)], 1'b0);
      end
   endtask

   task automatic add_random_source();
      int count;
      if ($urandom_range(9) == 0) begin
         count = $urandom_range(5, 20);
         for (int i = 0; i < count; i++) add_byte(8'($urandom_range(1, 255)), 1'b0);
      end else begin
         count = $urandom_range(3, 12);
         for (int i = 0; i < count; i++) add_random_token();
      end
      case ($urandom_range(2))
         0: add_byte(CH_NUL, 1'($urandom_range(1)));
         1: add_byte(tail_chars[$urandom_range(tail_chars.len() - 1)], 1'b1);
         default: add_byte(8'($urandom_range(1, 255)), 1'b1);
      endcase
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int unsigned random_start;
      clear_lexer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: pending symbol flushed by a zero byte, wrapping number,
      // high and control bytes, lookahead misses, comment, empty source
      add_text("if<", 1'b0);
      add_byte(CH_NUL, 1'b0);
      add_text("4294967297", 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h01, 1'b0);
      add_text("=/", 1'b1);
      add_text("a//", 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(CH_LF, 1'b0);
      add_text("!=", 1'b1);
      add_byte(CH_NUL, 1'b1);
      wait_drained();

      random_start = bytes_queued;
      while (bytes_queued - random_start < RANDOM_BYTES) add_random_source();
      wait_drained();

      repeat (20) @(negedge clock);
      $display("covered %0d bytes in %0d sources, %0d tokens checked, token limit hit %0d time(s)",
               bytes_accepted, sources_done, tokens_checked, limit_hits);
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/stt_pkg.sv
hdl/source_text_tokenizer.sv
tb/sv/tb.sv
